// ===== hdl/bmhpq_pkg.sv =====
// bmhpq_pkg: shared constants, codes and types of the max priority queue.
// Used by the cell row, the top level and the checker; depends on nothing else.
package bmhpq_pkg;

   localparam int DEPTH   = 64;
   localparam int KEY_W   = 32;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int EXT_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int TDATA_W = 48;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   typedef struct packed {
      op_type  op;
      key_type key;
   } cell_ctrl_type;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL_REJ   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY_REJ  = 2'd2;

endpackage

// ===== hdl/bmhpq_cell.sv =====
// bmhpq_cell: one slot of the sorted cell row, largest key in cell 0.
// Depends on bmhpq_pkg.
module bmhpq_cell (
   input  logic                   clock,
   input  bmhpq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  bmhpq_pkg::key_type     prev_data,
   input  logic                   prev_gt,
   input  bmhpq_pkg::key_type     next_data,
   output bmhpq_pkg::key_type     data,
   output logic                   gt
);
   import bmhpq_pkg::*;

   key_type data_ff;
   key_type data_in;

   // new key beats this slot; empty slots always lose
   assign gt = !occupied || (ctrl.key > data_ff);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_PUSH: begin
            if (gt) begin
               data_in = prev_gt ? prev_data : ctrl.key;
            end
         end
         OP_POP:  data_in = next_data;
         OP_HOLD: data_in = data_ff;
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hdl/binary_max_heap_priority_queue.sv =====
// binary_max_heap_priority_queue: max priority queue built as a row of
// DEPTH sorted cells. Depends on bmhpq_pkg and bmhpq_cell.
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  tuser kind, tdata key
//   rsp       out   rsp_tvalid/rsp_tready  tdata top_key,count,empty,full,status
//   csr       in    csr_we                 csr_wdata capacity
//
// the whole cell row shifts in the accept cycle, and the response beat
// appears in the next cycle from an output register.
// a new item is taken while the response register is empty or being drained.
// reset empties the queue and sets capacity to 64; no clearing pass.
module binary_max_heap_priority_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,  // [31:0] key
   input  logic                         req_tuser,  // [0] kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [31:0] top_key, [38:32] count, [39] is_empty, [40] is_full,
   // [42:41] status, [47:43] zero
   output logic [bmhpq_pkg::TDATA_W-1:0] rsp_tdata,
   input  logic                         csr_we,
   input  logic [bmhpq_pkg::CAP_W-1:0]  csr_wdata
);
   import bmhpq_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_valid_ff;
   logic [TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   key_type       cell_data [DEPTH];
   logic          cell_gt   [DEPTH];
   cell_ctrl_type ctrl;

   logic [EXT_W-1:0] cap_ext, cap_eff, cnt_ext, cnt_new_ext;
   logic             accept, is_insert, full_now, empty_now;
   logic             new_full, new_empty;
   logic [1:0]       status;
   key_type          top_new;
   key_type          key_in;

   assign key_in    = key_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign is_insert = (req_tuser == KIND_INSERT);

   assign cap_ext  = EXT_W'(cap_ff);
   assign cap_eff  = (cap_ext > EXT_W'(DEPTH)) ? EXT_W'(DEPTH) : cap_ext;
   assign cnt_ext  = EXT_W'(count_ff);
   assign full_now  = (cnt_ext >= cap_eff);
   assign empty_now = (count_ff == '0);

   always_comb begin
      ctrl.key = key_in;
      ctrl.op  = OP_HOLD;
      count_in = count_ff;
      status   = STATUS_DONE;
      top_new  = empty_now ? '0 : cell_data[0];
      if (is_insert) begin
         if (full_now) begin
            status = STATUS_FULL_REJ;
         end else begin
            ctrl.op  = accept ? OP_PUSH : OP_HOLD;
            count_in = count_ff + 1'b1;
            top_new  = cell_gt[0] ? key_in : cell_data[0];
         end
      end else begin
         if (empty_now) begin
            status = STATUS_EMPTY_REJ;
         end else begin
            ctrl.op  = accept ? OP_POP : OP_HOLD;
            count_in = count_ff - 1'b1;
            top_new  = (count_ff > CNT_W'(1)) ? cell_data[1] : '0;
         end
      end
   end

   assign cnt_new_ext = EXT_W'(count_in);
   assign new_full    = (cnt_new_ext >= cap_eff);
   assign new_empty   = (count_in == '0);
   assign rsp_data_in = {5'b0, status, new_full, new_empty,
                         COUNT_W'(count_in), top_new};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      key_type prev_d, next_d;
      logic    prev_g;
      if (i == 0) begin : g_head
         assign prev_d = '0;
         assign prev_g = 1'b0;
      end else begin : g_body
         assign prev_d = cell_data[i-1];
         assign prev_g = cell_gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_mid
         assign next_d = cell_data[i+1];
      end
      bmhpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (count_ff > CNT_W'(i)),
         .prev_data (prev_d),
         .prev_gt   (prev_g),
         .next_data (next_d),
         .data      (cell_data[i]),
         .gt        (cell_gt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/bmhpq_checker.sv =====
// bmhpq_checker: port-level checks on the priority queue response beats,
// bound to the top level. Depends on bmhpq_pkg.
module bmhpq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bmhpq_pkg::TDATA_W-1:0] rsp_tdata
);
   import bmhpq_pkg::*;

   // a stalled beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // empty flag tracks count, and an empty queue shows a zero top key
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39] == (rsp_tdata[38:32] == '0)) &&
                     (!rsp_tdata[39] || rsp_tdata[31:0] == '0))
      else $error("empty flag, count and top key disagree");

   // count never passes the store depth and status stays a known code
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38:32] <= COUNT_W'(DEPTH)) &&
                     (rsp_tdata[42:41] != 2'd3))
      else $error("count or status out of range");

   // a rejected remove only happens on an empty queue, a rejected insert on a full one
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[42:41] != STATUS_EMPTY_REJ || rsp_tdata[39]) &&
                     (rsp_tdata[42:41] != STATUS_FULL_REJ || rsp_tdata[40]))
      else $error("rejection status without matching flag");

endmodule

bind binary_max_heap_priority_queue bmhpq_checker u_bmhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
